// ===== rtl/pfa_pkg.sv =====
// Shared types and codes for the partition fit allocator.
package pfa_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_SET   = 2'd0;
	localparam logic [1:0] REQ_PLACE = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;

	// Placement policy codes held in the fit_policy register.
	localparam logic [1:0] POLICY_FIRST = 2'd0;
	localparam logic [1:0] POLICY_BEST  = 2'd1;
	localparam logic [1:0] POLICY_WORST = 2'd2;

	// Configuration register indexes and port widths.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITIONS_USED = 1'd1;

	localparam logic [1:0] FIT_POLICY_RESET = POLICY_FIRST;
	localparam logic [4:0] PARTS_RESET      = 5'd16;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [3:0]  slot_index;
		logic [15:0] amount;
	} in_item_t;

	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_slot;
		logic [15:0] leftover;
	} out_item_t;

endpackage

// ===== rtl/pfa_size_mem.sv =====
// Partition size memory: one write port, one registered read port, reads zero until written.
module pfa_size_mem #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 16,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  written_q;
	logic [DATA_W-1:0] rd_data_s1;
	logic              rd_written_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// A size that was never set reads as zero, as after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q     <= '0;
			rd_written_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_s1 <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_s1 ? rd_data_s1 : '0;

endmodule

// ===== rtl/pfa_fit_unit.sv =====
// Shared subtract and compare unit that keeps the running best candidate of a scan.
module pfa_fit_unit #(
	parameter int SIZE_BITS = 16,
	parameter int ADDR_W    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 cand_valid,
	input  logic [ADDR_W-1:0]    cand_idx,
	input  logic [SIZE_BITS-1:0] cand_size,
	input  logic                 cand_used,
	input  logic [SIZE_BITS-1:0] need,
	input  logic [1:0]           policy,
	output logic                 found,
	output logic [ADDR_W-1:0]    best_idx,
	output logic [SIZE_BITS-1:0] best_left
);

	logic [SIZE_BITS:0]   diff;
	logic [SIZE_BITS-1:0] rem;
	logic                 fits;
	logic                 better;
	logic                 take;
	logic                 found_q;
	logic [ADDR_W-1:0]    best_idx_q;
	logic [SIZE_BITS-1:0] best_left_q;

	// The borrow of the subtraction tells whether the process fits.
	assign diff = {1'b0, cand_size} - {1'b0, need};
	assign rem  = diff[SIZE_BITS-1:0];
	assign fits = !cand_used && !diff[SIZE_BITS];

	always_comb begin
		case (policy)
			pfa_pkg::POLICY_BEST:  better = rem < best_left_q;
			pfa_pkg::POLICY_WORST: better = rem > best_left_q;
			default:               better = 1'b0;
		endcase
	end

	// Strict compares keep the lowest index on a tie.
	assign take = cand_valid && fits && (!found_q || better);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= cand_idx;
			best_left_q <= rem;
		end
	end

	assign found     = found_q;
	assign best_idx  = best_idx_q;
	assign best_left = best_left_q;

endmodule

// ===== rtl/partition_fit_allocator.sv =====
// A place request scans min(partitions_in_use, NUM_SLOTS) partitions, since one subtract and
// compare unit visits one partition per cycle from the single read port of the size memory;
// set, free and place with no partitions in use go straight to the result state. The block
// takes no new item while a request is at work, but it does accept one while a result waits
// in the output register. Unset partition sizes read as zero and no clearing pass is needed.
module partition_fit_allocator #(
	parameter int NUM_SLOTS = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  pfa_pkg::in_item_t                   in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output pfa_pkg::out_item_t                  out_item
);

	localparam int ADDR_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W  = ($clog2(NUM_SLOTS + 1) > 5) ? $clog2(NUM_SLOTS + 1) : 5;
	localparam int IDX_W  = (ADDR_W > 4) ? ADDR_W : 4;
	localparam int AMT_W  = (SIZE_BITS > 16) ? SIZE_BITS : 16;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_RESULT = 4'b1000
	} state_t;

	state_t               state_q;
	logic [1:0]           fit_policy_q;
	logic [4:0]           parts_q;
	logic [NUM_SLOTS-1:0] used_q;
	logic [SIZE_BITS-1:0] amt_q;
	logic                 place_q;
	logic [ADDR_W-1:0]    ptr_q;
	logic [ADDR_W-1:0]    last_q;
	logic                 cand_valid_s1;
	logic [ADDR_W-1:0]    cand_idx_s1;
	logic                 cand_used_s1;
	logic                 out_valid_q;
	pfa_pkg::out_item_t   out_q;

	logic                 accept;
	logic                 out_free;
	logic [AMT_W-1:0]     amt_wide;
	logic [SIZE_BITS-1:0] amt_in;
	logic [CNT_W-1:0]     parts_ext;
	logic [CNT_W-1:0]     count;
	logic [CNT_W-1:0]     count_m1;
	logic [IDX_W-1:0]     set_idx_wide;
	logic                 set_idx_ok;
	logic                 mem_we;
	logic [SIZE_BITS-1:0] cand_size;
	logic                 found;
	logic [ADDR_W-1:0]    best_idx;
	logic [SIZE_BITS-1:0] best_left;
	logic                 grant;
	logic [IDX_W-1:0]     best_idx_wide;
	logic [AMT_W-1:0]     best_left_wide;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;

	assign amt_wide = AMT_W'(in_item.amount);
	assign amt_in   = amt_wide[SIZE_BITS-1:0];

	// Search length saturates at the number of partitions built.
	assign parts_ext = CNT_W'(parts_q);
	assign count     = (parts_ext > CNT_W'(NUM_SLOTS)) ? CNT_W'(NUM_SLOTS) : parts_ext;
	assign count_m1  = count - CNT_W'(1);

	// One extra bit keeps the slot count from wrapping to zero in the compare.
	assign set_idx_wide = IDX_W'(in_item.slot_index);
	assign set_idx_ok   = {1'b0, set_idx_wide} < (IDX_W + 1)'(NUM_SLOTS);
	assign mem_we       = accept && (in_item.req_type == pfa_pkg::REQ_SET) && set_idx_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= pfa_pkg::FIT_POLICY_RESET;
			parts_q      <= pfa_pkg::PARTS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				pfa_pkg::CFG_FIT_POLICY:      fit_policy_q <= cfg_data[1:0];
				pfa_pkg::CFG_PARTITIONS_USED: parts_q      <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			used_q        <= '0;
			place_q       <= 1'b0;
			ptr_q         <= '0;
			last_q        <= '0;
			cand_valid_s1 <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			cand_valid_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						place_q <= (in_item.req_type == pfa_pkg::REQ_PLACE);
						ptr_q   <= '0;
						last_q  <= count_m1[ADDR_W-1:0];
						if (in_item.req_type == pfa_pkg::REQ_FREE) begin
							used_q <= '0;
						end
						if (in_item.req_type == pfa_pkg::REQ_PLACE && count != '0) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RESULT;
						end
					end
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + ADDR_W'(1);
					if (ptr_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						if (grant) begin
							used_q[best_idx] <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amt_q <= amt_in;
		end
		cand_idx_s1  <= ptr_q;
		cand_used_s1 <= used_q[ptr_q];
		if (state_q == ST_RESULT && out_free) begin
			out_q.granted     <= grant;
			out_q.chosen_slot <= grant ? best_idx_wide[3:0] : 4'd0;
			out_q.leftover    <= grant ? best_left_wide[15:0] : 16'd0;
		end
	end

	assign grant          = place_q && found;
	assign best_idx_wide  = IDX_W'(best_idx);
	assign best_left_wide = AMT_W'(best_left);

	pfa_size_mem #(
		.DEPTH  (NUM_SLOTS),
		.DATA_W (SIZE_BITS),
		.ADDR_W (ADDR_W)
	) u_size_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mem_we),
		.wr_addr (set_idx_wide[ADDR_W-1:0]),
		.wr_data (amt_in),
		.rd_addr (ptr_q),
		.rd_data (cand_size)
	);

	pfa_fit_unit #(
		.SIZE_BITS (SIZE_BITS),
		.ADDR_W    (ADDR_W)
	) u_fit_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (accept),
		.cand_valid (cand_valid_s1),
		.cand_idx   (cand_idx_s1),
		.cand_size  (cand_size),
		.cand_used  (cand_used_s1),
		.need       (amt_q),
		.policy     (fit_policy_q),
		.found      (found),
		.best_idx   (best_idx),
		.best_left  (best_left)
	);

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== rtl/pfa_checker.sv =====
// Port-level checks for the partition fit allocator, bound to the top level.
module pfa_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input pfa_pkg::out_item_t out_item
);

	// Every request keeps the block busy in the cycle after it is accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready stayed high after an item was accepted");

	// A result is only loaded while a request is at work.
	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a request at work");

	// A refused or non-place result carries zero index and leftover.
	a_zero_when_refused: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.granted |-> out_item.chosen_slot == 4'd0 &&
			out_item.leftover == 16'd0)
		else $error("result without a grant has nonzero fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed or was dropped");

endmodule

bind partition_fit_allocator pfa_checker u_pfa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ===== tb/partition_fit_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the partition fit allocator: directed fits, then random traffic.
module partition_fit_allocator_test;

	localparam int SLOTS = 16;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 200;

	// Codes the package leaves unnamed; the block must tolerate them.
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [1:0] POLICY_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [pfa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	pfa_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	pfa_pkg::out_item_t out_item;

	logic [15:0] part_size [SLOTS];
	logic part_used [SLOTS];
	logic [1:0] cur_policy;
	logic [4:0] cur_parts;
	pfa_pkg::out_item_t pending_grants [$];
	int errors = 0;
	int quiet = 0;
	int stall_left = 0;
	bit steady = 1'b0;

	partition_fit_allocator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 45) return 0;
		if (r < 85) return int'($urandom_range(1, 3));
		if (r < 96) return int'($urandom_range(4, 12));
		return int'($urandom_range(20, 60));
	endfunction

	// Works out the result of one request and updates the shadow partition table.
	function automatic pfa_pkg::out_item_t expected_grant(input pfa_pkg::in_item_t req);
		pfa_pkg::out_item_t res;
		int count;
		int i;
		bit found;
		logic [15:0] rem;
		logic [15:0] best_rem;
		logic [3:0] best_slot;
		res = '0;
		found = 1'b0;
		best_rem = '0;
		best_slot = '0;
		count = (int'(cur_parts) > SLOTS) ? SLOTS : int'(cur_parts);
		case (req.req_type)
			pfa_pkg::REQ_SET: begin
				part_size[req.slot_index] = req.amount;
			end
			pfa_pkg::REQ_PLACE: begin
				for (i = 0; i < count; i++) begin
					if (!part_used[i] && part_size[i] >= req.amount) begin
						rem = part_size[i] - req.amount;
						if (!found || (cur_policy == pfa_pkg::POLICY_BEST && rem < best_rem)
								|| (cur_policy == pfa_pkg::POLICY_WORST
								&& rem > best_rem)) begin
							found = 1'b1;
							best_slot = i[3:0];
							best_rem = rem;
						end
						// Any policy code other than best or worst behaves as first fit.
						if (cur_policy != pfa_pkg::POLICY_BEST
								&& cur_policy != pfa_pkg::POLICY_WORST)
							break;
					end
				end
				if (found) begin
					part_used[best_slot] = 1'b1;
					res.granted = 1'b1;
					res.chosen_slot = best_slot;
					res.leftover = best_rem;
				end
			end
			pfa_pkg::REQ_FREE: begin
				for (i = 0; i < SLOTS; i++)
					part_used[i] = 1'b0;
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	task automatic check_grant(input pfa_pkg::out_item_t got);
		pfa_pkg::out_item_t want;
		if (pending_grants.size() == 0) begin
			$display("%0t: unexpected result: granted %0d slot %0d leftover %0d",
				$time, got.granted, got.chosen_slot, got.leftover);
			errors++;
			return;
		end
		want = pending_grants.pop_front();
		if (got.granted !== want.granted) begin
			$display("%0t: granted expected %0d actual %0d", $time, want.granted, got.granted);
			errors++;
		end
		if (got.chosen_slot !== want.chosen_slot) begin
			$display("%0t: chosen_slot expected %0d actual %0d",
				$time, want.chosen_slot, got.chosen_slot);
			errors++;
		end
		if (got.leftover !== want.leftover) begin
			$display("%0t: leftover expected %0d actual %0d",
				$time, want.leftover, got.leftover);
			errors++;
		end
	endtask

	task automatic send_item(input logic [1:0] req, input logic [3:0] idx,
			input logic [15:0] amt);
		pfa_pkg::in_item_t item;
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.req_type = req;
		item.slot_index = idx;
		item.amount = amt;
		in_item <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_grants.push_back(expected_grant(item));
	endtask

	// Holds the sender until every outstanding result has come back and the block is idle.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pfa_pkg::CFG_IDX_W-1:0] idx,
			input logic [pfa_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pfa_pkg::CFG_FIT_POLICY)
			cur_policy = data[1:0];
		else
			cur_parts = data;
		@(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		send_item(pfa_pkg::REQ_PLACE, 4'd15, 16'd1);
		send_item(pfa_pkg::REQ_FREE, 4'd0, 16'd0);
	endtask

	task automatic test_fit_policies();
		send_item(pfa_pkg::REQ_SET, 4'd3, 16'hFFFF);
		send_item(pfa_pkg::REQ_SET, 4'd7, 16'd100);
		send_item(pfa_pkg::REQ_SET, 4'd9, 16'd100);
		send_item(pfa_pkg::REQ_SET, 4'd15, 16'd50);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd60);
		settle();
		write_reg(pfa_pkg::CFG_FIT_POLICY, 5'(pfa_pkg::POLICY_BEST));
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd40);
		// Two partitions fit exactly here; the lower index must win.
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd100);
		settle();
		write_reg(pfa_pkg::CFG_FIT_POLICY, 5'(pfa_pkg::POLICY_WORST));
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		send_item(pfa_pkg::REQ_FREE, 4'd15, 16'hFFFF);
		send_item(pfa_pkg::REQ_PLACE, 4'd15, 16'hFFFF);
		// Resizing a used partition must not free it.
		send_item(pfa_pkg::REQ_SET, 4'd3, 16'd0);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
	endtask

	task automatic test_config_limits();
		send_item(REQ_UNUSED, 4'd15, 16'hFFFF);
		settle();
		write_reg(pfa_pkg::CFG_PARTITIONS_USED, 5'd0);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		settle();
		write_reg(pfa_pkg::CFG_FIT_POLICY, 5'(POLICY_UNUSED));
		write_reg(pfa_pkg::CFG_PARTITIONS_USED, 5'd31);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd50);
		settle();
		write_reg(pfa_pkg::CFG_PARTITIONS_USED, 5'd1);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		send_item(pfa_pkg::REQ_PLACE, 4'd0, 16'd0);
		send_item(pfa_pkg::REQ_FREE, 4'd0, 16'd0);
	endtask

	function automatic logic [15:0] random_size();
		int r;
		r = int'($urandom_range(0, 99));
		if (r < 40) return 16'($urandom_range(0, 255));
		// Coarse sizes make equal leftovers, and so ties, common.
		if (r < 60) return 16'($urandom_range(0, 15) * 64);
		if (r < 90) return 16'($urandom_range(0, 65535));
		if (r < 95) return 16'hFFFF;
		return 16'd0;
	endfunction

	task automatic test_random_traffic();
		int phase;
		int n;
		int r;
		logic [4:0] parts;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle();
			steady = (phase % 3 == 2);
			if ($urandom_range(0, 4) == 0)
				write_reg(pfa_pkg::CFG_FIT_POLICY, 5'($urandom_range(0, 31)));
			else
				write_reg(pfa_pkg::CFG_FIT_POLICY, 5'(phase % 4));
			r = int'($urandom_range(0, 99));
			if (phase == 0 || r < 15) parts = 5'd16;
			else if (r < 70) parts = 5'($urandom_range(1, 16));
			else if (r < 80) parts = 5'd0;
			else parts = 5'($urandom_range(17, 31));
			write_reg(pfa_pkg::CFG_PARTITIONS_USED, parts);
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				r = int'($urandom_range(0, 99));
				if (r < 30)
					send_item(pfa_pkg::REQ_SET, 4'($urandom_range(0, 15)), random_size());
				else if (r < 86 && $urandom_range(0, 3) == 0)
					send_item(pfa_pkg::REQ_PLACE, 4'($urandom_range(0, 15)),
						part_size[$urandom_range(0, SLOTS - 1)]);
				else if (r < 86)
					send_item(pfa_pkg::REQ_PLACE, 4'($urandom_range(0, 15)),
						random_size());
				else if (r < 95)
					send_item(pfa_pkg::REQ_FREE, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
				else
					send_item(REQ_UNUSED, 4'($urandom_range(0, 15)),
						16'($urandom_range(0, 65535)));
			end
		end
		steady = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_grant(out_item);
			if (stall_left > 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left = idle_len();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("[partition_fit_allocator] ERROR");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			part_size[i] = '0;
			part_used[i] = 1'b0;
		end
		cur_policy = pfa_pkg::FIT_POLICY_RESET;
		cur_parts = pfa_pkg::PARTS_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_fit_policies();
		test_config_limits();
		test_random_traffic();
		settle();
		if (errors == 0)
			$display("[partition_fit_allocator] OK");
		else
			$display("[partition_fit_allocator] ERROR");
		$finish;
	end

endmodule
